// ===== hdl/mmh_pkg.sv =====
`timescale 1ns / 1ps
package mmh_pkg;

   localparam int unsigned WORD_W = 64;
   localparam int unsigned SIZE_W = 13;

   localparam logic [WORD_W-1:0] MUR_M    = 64'hc6a4a7935bd1e995;
   localparam logic [WORD_W-1:0] MUR_SEED = 64'h00000000e17a1465;
   localparam int unsigned       MUR_R    = 47;

   // record length after reset and the matching starting hash
   localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd8;
   localparam logic [WORD_W-1:0] INIT_RESET = MUR_SEED ^ (MUR_M * 64'd8);

   // constant multiplier: one 32x32 partial product per stage
   localparam int unsigned MUL_LAT = 3;
   localparam int unsigned CNT_W   = $clog2(MUL_LAT);

   // queue between front and back
   localparam int unsigned QDEPTH  = 8;
   localparam int unsigned QPTR_W  = $clog2(QDEPTH);
   localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

   // item moving through the front mixing pipeline
   typedef struct packed {
      logic              valid;
      logic              bypass;
      logic              last;
      logic [WORD_W-1:0] word;
   } side_type;

   // queued item: value to xor into the running hash
   typedef struct packed {
      logic              last;
      logic [WORD_W-1:0] word;
   } entry_type;

   // record length load from the front to the back
   typedef struct packed {
      logic              load;
      logic [SIZE_W-1:0] eff_size;
   } cfg_type;

endpackage

// ===== hdl/mmh_mul.sv =====
`timescale 1ns / 1ps
module mmh_mul (
   input  logic                       clock,
   input  logic [mmh_pkg::WORD_W-1:0] mul_a,
   output logic [mmh_pkg::WORD_W-1:0] mul_p
);

   localparam logic [31:0] M_LO = mmh_pkg::MUR_M[31:0];
   localparam logic [31:0] M_HI = mmh_pkg::MUR_M[63:32];

   logic [63:0] p1_ff, p1_in;
   logic [31:0] lo1_ff, hi1_ff;
   logic [63:0] p2_ff, p2_in;
   logic [31:0] hi2_ff;
   logic [63:0] p3_ff, p3_in;
   logic [31:0] cross2, cross3;

   // product mod 2^64 = lo*mlo + ((lo*mhi + hi*mlo) << 32)
   always_comb begin
      p1_in  = {32'd0, mul_a[31:0]} * {32'd0, M_LO};
      cross2 = lo1_ff * M_HI;
      p2_in  = {p1_ff[63:32] + cross2, p1_ff[31:0]};
      cross3 = hi2_ff * M_LO;
      p3_in  = {p2_ff[63:32] + cross3, p2_ff[31:0]};
   end

   always_ff @(posedge clock) begin
      p1_ff  <= p1_in;
      lo1_ff <= mul_a[31:0];
      hi1_ff <= mul_a[63:32];
      p2_ff  <= p2_in;
      hi2_ff <= hi1_ff;
      p3_ff  <= p3_in;
   end

   assign mul_p = p3_ff;

endmodule

// ===== hdl/mmh_front.sv =====
`timescale 1ns / 1ps
module mmh_front #(
   parameter int unsigned MAX_RECORD_BYTES = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [mmh_pkg::WORD_W-1:0] req_data_word,
   input  logic                       csr_write_enable,
   input  logic [mmh_pkg::SIZE_W-1:0] csr_record_size,
   output logic                       q_push,
   output mmh_pkg::entry_type         q_entry,
   input  logic                       q_pop,
   output mmh_pkg::cfg_type           cfg
);

   localparam int unsigned IDX_W =
      ($clog2(MAX_RECORD_BYTES / 8) > 0) ? $clog2(MAX_RECORD_BYTES / 8) : 1;
   localparam int unsigned STAGES = 2 * mmh_pkg::MUL_LAT;

   logic [IDX_W-1:0]          widx_ff, widx_in;
   logic [IDX_W-1:0]          lastidx_ff, lastidx_in;
   logic [2:0]                tail_ff, tail_in;
   logic [mmh_pkg::QCNT_W-1:0] credit_ff, credit_in;
   mmh_pkg::side_type         side_ff [STAGES];
   mmh_pkg::side_type         side_in;

   logic [mmh_pkg::SIZE_W-1:0] eff_size;
   logic [mmh_pkg::SIZE_W-1:0] size_m1;
   logic                       accept;
   logic                       is_last;
   logic [mmh_pkg::WORD_W-1:0] tail_mask;
   logic [mmh_pkg::WORD_W-1:0] k_a, k_mid, k_b;

   // clamp the written size into one byte .. MAX_RECORD_BYTES
   always_comb begin
      eff_size = csr_record_size;
      if (csr_record_size == '0) begin
         eff_size = mmh_pkg::SIZE_W'(1);
      end else if (32'(csr_record_size) > MAX_RECORD_BYTES) begin
         eff_size = mmh_pkg::SIZE_W'(MAX_RECORD_BYTES);
      end
      size_m1    = eff_size - mmh_pkg::SIZE_W'(1);
      lastidx_in = IDX_W'(size_m1 >> 3);
      tail_in    = eff_size[2:0];
   end

   assign req_ready = (credit_ff != '0);
   assign accept    = req_valid && req_ready;
   assign is_last   = (widx_ff == lastidx_ff);
   assign tail_mask = ~({mmh_pkg::WORD_W{1'b1}} << {tail_ff, 3'b000});

   always_comb begin
      side_in.valid  = accept;
      side_in.last   = is_last;
      side_in.bypass = is_last && (tail_ff != 3'd0);
      side_in.word   = req_data_word & tail_mask;
   end

   always_comb begin
      widx_in = widx_ff;
      if (csr_write_enable) begin
         widx_in = '0;
      end else if (accept) begin
         widx_in = is_last ? '0 : widx_ff + IDX_W'(1);
      end
      credit_in = credit_ff;
      if (accept && !q_pop) begin
         credit_in = credit_ff - mmh_pkg::QCNT_W'(1);
      end else if (!accept && q_pop) begin
         credit_in = credit_ff + mmh_pkg::QCNT_W'(1);
      end
   end

   // k *= M; k ^= k >> 47; k *= M
   mmh_mul u_mul_a (
      .clock (clock),
      .mul_a (req_data_word),
      .mul_p (k_a)
   );

   assign k_mid = k_a ^ (k_a >> mmh_pkg::MUR_R);

   mmh_mul u_mul_b (
      .clock (clock),
      .mul_a (k_mid),
      .mul_p (k_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         widx_ff    <= '0;
         lastidx_ff <= '0;
         tail_ff    <= mmh_pkg::SIZE_RESET[2:0];
         credit_ff  <= mmh_pkg::QCNT_W'(mmh_pkg::QDEPTH);
         for (int i = 0; i < STAGES; i++) begin
            side_ff[i].valid <= 1'b0;
         end
      end else begin
         widx_ff   <= widx_in;
         credit_ff <= credit_in;
         if (csr_write_enable) begin
            lastidx_ff <= lastidx_in;
            tail_ff    <= tail_in;
         end
         side_ff[0].valid <= side_in.valid;
         for (int i = 1; i < STAGES; i++) begin
            side_ff[i].valid <= side_ff[i-1].valid;
         end
      end
      side_ff[0].bypass <= side_in.bypass;
      side_ff[0].last   <= side_in.last;
      side_ff[0].word   <= side_in.word;
      for (int i = 1; i < STAGES; i++) begin
         side_ff[i].bypass <= side_ff[i-1].bypass;
         side_ff[i].last   <= side_ff[i-1].last;
         side_ff[i].word   <= side_ff[i-1].word;
      end
   end

   // a partial final word skips the key mixing and goes in masked
   assign q_push        = side_ff[STAGES-1].valid;
   assign q_entry.last  = side_ff[STAGES-1].last;
   assign q_entry.word  = side_ff[STAGES-1].bypass ? side_ff[STAGES-1].word : k_b;
   assign cfg.load      = csr_write_enable;
   assign cfg.eff_size  = eff_size;

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= mmh_pkg::QCNT_W'(mmh_pkg::QDEPTH))
      else $error("front credit above queue depth");

endmodule

// ===== hdl/mmh_fifo.sv =====
`timescale 1ns / 1ps
module mmh_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_push,
   input  mmh_pkg::entry_type q_entry,
   input  logic               q_pop,
   output logic               q_empty,
   output mmh_pkg::entry_type q_head
);

   mmh_pkg::entry_type             mem_ff [mmh_pkg::QDEPTH];
   logic [mmh_pkg::QPTR_W-1:0]     wr_ff, rd_ff;
   logic [mmh_pkg::QCNT_W-1:0]     count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (q_push && !q_pop) begin
         count_in = count_ff + mmh_pkg::QCNT_W'(1);
      end else if (!q_push && q_pop) begin
         count_in = count_ff - mmh_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (q_push) begin
            wr_ff <= wr_ff + mmh_pkg::QPTR_W'(1);
         end
         if (q_pop) begin
            rd_ff <= rd_ff + mmh_pkg::QPTR_W'(1);
         end
      end
      if (q_push) begin
         mem_ff[wr_ff] <= q_entry;
      end
   end

   assign q_empty = (count_ff == '0);
   assign q_head  = mem_ff[rd_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (count_ff != mmh_pkg::QCNT_W'(mmh_pkg::QDEPTH)) || q_pop)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue pop while empty");

endmodule

// ===== hdl/mmh_back.sv =====
`timescale 1ns / 1ps
module mmh_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_empty,
   input  mmh_pkg::entry_type         q_head,
   output logic                       q_pop,
   input  mmh_pkg::cfg_type           cfg,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [mmh_pkg::WORD_W-1:0] rsp_hash_value
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HMUL,
      ST_FMUL,
      ST_EMIT
   } state_type;

   state_type                  state_ff;
   logic [mmh_pkg::CNT_W-1:0]  cnt_ff;
   logic                       last_ff;
   logic [mmh_pkg::WORD_W-1:0] h_ff;
   logic [mmh_pkg::WORD_W-1:0] init_ff, init_in;
   logic [mmh_pkg::WORD_W-1:0] fin_ff;
   logic                       rsp_valid_ff;
   logic [mmh_pkg::WORD_W-1:0] rsp_hash_ff;

   logic                       mul_done;
   logic                       rsp_load;
   logic [mmh_pkg::WORD_W-1:0] mul_a, mul_p;
   logic [mmh_pkg::WORD_W-1:0] p_fold;

   assign init_in  = mmh_pkg::MUR_SEED ^
                     ({{(mmh_pkg::WORD_W - mmh_pkg::SIZE_W){1'b0}}, cfg.eff_size} *
                      mmh_pkg::MUR_M);
   assign mul_done = (cnt_ff == mmh_pkg::CNT_W'(mmh_pkg::MUL_LAT - 1));
   assign p_fold   = mul_p ^ (mul_p >> mmh_pkg::MUR_R);
   assign rsp_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   // chain the next word straight off the finished product when one is queued
   always_comb begin
      q_pop = 1'b0;
      mul_a = h_ff ^ q_head.word;
      unique case (state_ff)
         ST_IDLE: begin
            q_pop = !q_empty;
         end
         ST_HMUL: begin
            if (mul_done) begin
               if (last_ff) begin
                  mul_a = p_fold;
               end else begin
                  mul_a = mul_p ^ q_head.word;
                  q_pop = !q_empty;
               end
            end
         end
         ST_FMUL, ST_EMIT: begin
            q_pop = 1'b0;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   mmh_mul u_mul_h (
      .clock (clock),
      .mul_a (mul_a),
      .mul_p (mul_p)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         h_ff         <= mmh_pkg::INIT_RESET;
         init_ff      <= mmh_pkg::INIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // user changes size only while idle (unchecked); restart the record
         if (cfg.load) begin
            init_ff <= init_in;
            h_ff    <= init_in;
         end else begin
            unique case (state_ff)
               ST_IDLE: begin
                  cnt_ff <= '0;
                  if (!q_empty) begin
                     last_ff  <= q_head.last;
                     state_ff <= ST_HMUL;
                  end
               end
               ST_HMUL: begin
                  if (mul_done) begin
                     cnt_ff <= '0;
                     if (last_ff) begin
                        h_ff     <= init_ff;
                        state_ff <= ST_FMUL;
                     end else begin
                        h_ff <= mul_p;
                        if (!q_empty) begin
                           last_ff <= q_head.last;
                        end else begin
                           state_ff <= ST_IDLE;
                        end
                     end
                  end else begin
                     cnt_ff <= cnt_ff + mmh_pkg::CNT_W'(1);
                  end
               end
               ST_FMUL: begin
                  if (mul_done) begin
                     cnt_ff   <= '0;
                     fin_ff   <= p_fold;
                     state_ff <= ST_EMIT;
                  end else begin
                     cnt_ff <= cnt_ff + mmh_pkg::CNT_W'(1);
                  end
               end
               ST_EMIT: begin
                  // hold the hash until the output register frees up
                  if (rsp_load) begin
                     rsp_hash_ff <= fin_ff;
                     state_ff    <= ST_IDLE;
                  end
               end
               default: begin
                  state_ff <= ST_IDLE;
               end
            endcase
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= mmh_pkg::CNT_W'(mmh_pkg::MUL_LAT - 1))
      else $error("multiply counter out of range");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && (!rsp_valid_ff || rsp_ready)) |=>
         (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished hash not moved to output");

endmodule

// ===== hdl/murmur64a_record_hash.sv =====
`timescale 1ns / 1ps
// MurmurHash64A of fixed-length records.
// Input channel req_*: one 64-bit little-endian record word per item,
// ceil(size/8) items per record. Output channel rsp_*: one 64-bit hash item
// per record, issued after the record's last word. csr_record_size sets the
// record length in bytes (zero acts as one, longer than MAX_RECORD_BYTES is
// clamped); write it only while no record is in flight, it restarts the
// record count.
// Pipeline: the front mixes each word through two 3-stage multipliers into an
// 8-entry queue; the back folds each word into the running hash with the
// dependent h*M product through its 3-stage multiplier, starting on a new
// word only once the previous product is finished. After a record's last
// word it folds the product, multiplies by M again and folds once more
// before the hash goes to the output register.
// Reset restores a record size of 8 bytes; no clearing pass is needed.
// When rsp_ready is low the finished hash waits in the output register, the
// back keeps working on queued words until a second hash is ready, and
// req_ready drops once the queue and front pipeline hold 8 words.
module murmur64a_record_hash #(
   parameter int unsigned MAX_RECORD_BYTES = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [mmh_pkg::WORD_W-1:0] req_data_word,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [mmh_pkg::WORD_W-1:0] rsp_hash_value,
   input  logic                       csr_write_enable,
   input  logic [mmh_pkg::SIZE_W-1:0] csr_record_size
);

   logic               q_push;
   logic               q_pop;
   logic               q_empty;
   mmh_pkg::entry_type q_entry;
   mmh_pkg::entry_type q_head;
   mmh_pkg::cfg_type   cfg;

   mmh_front #(
      .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_word    (req_data_word),
      .csr_write_enable (csr_write_enable),
      .csr_record_size  (csr_record_size),
      .q_push           (q_push),
      .q_entry          (q_entry),
      .q_pop            (q_pop),
      .cfg              (cfg)
   );

   mmh_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_entry (q_entry),
      .q_pop   (q_pop),
      .q_empty (q_empty),
      .q_head  (q_head)
   );

   mmh_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .cfg            (cfg),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule
